### design/ssn_pkg.sv
// shared types and constants for the segment sum normaliser
// no dependencies; used by every module of the block
package ssn_pkg;

    localparam int VAL_W = 16;
    localparam int SUM_W = 32;
    localparam int BIN_W = 6;
    localparam int MAX_BINS = 1 << BIN_W;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_ACC   = 2'd1;
    localparam logic [1:0] REQ_NORM  = 2'd2;

    localparam logic [SUM_W-1:0] Q88_ONE   = 32'h0000_0100;
    localparam logic [SUM_W-1:0] INT32_MAX = 32'h7FFF_FFFF;

    localparam int QUEUE_DEPTH = 2;
    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    // one normalise job handed from front to back
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic signed [SUM_W-1:0] divisor;
        logic                    zero;
    } t_norm_job;

endpackage

### design/ssn_front.sv
// front end: accepts transactions, keeps the per-bin sums and valid bits,
// does the accumulate read-modify-write and hands normalise jobs on; uses ssn_pkg
module ssn_front #(
    parameter int NUM_BINS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [1:0]                         i_req_type,
    input  logic signed [ssn_pkg::VAL_W-1:0]   i_sample_value,
    input  logic [ssn_pkg::BIN_W-1:0]          i_bin_index,
    output logic                               o_push,
    output ssn_pkg::t_norm_job                 o_job,
    input  logic                               i_full
);

    localparam int DEPTH = (NUM_BINS < ssn_pkg::MAX_BINS) ? NUM_BINS : ssn_pkg::MAX_BINS;
    localparam int IW = $clog2(DEPTH);

    logic [ssn_pkg::SUM_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]          r_valid;

    logic                             r_pend;
    logic [1:0]                       r_type;
    logic signed [ssn_pkg::VAL_W-1:0] r_value;
    logic [IW-1:0]                    r_idx;
    logic                             r_in_range;
    logic                             r_hit;
    logic [ssn_pkg::SUM_W-1:0]        r_rd_data;

    logic                      accept;
    logic                      in_range;
    logic [IW-1:0]             idx;
    logic [ssn_pkg::SUM_W-1:0] cur;
    logic [ssn_pkg::SUM_W:0]   wide;
    logic [ssn_pkg::SUM_W-1:0] n_sum;
    logic                      exec_done;
    logic                      acc_write;

    assign accept   = i_start && !r_pend;
    assign in_range = 32'(i_bin_index) < NUM_BINS;
    assign idx      = i_bin_index[IW-1:0];
    assign o_busy   = r_pend;

    // a bin that was never written since the last clear counts as zero
    assign cur  = r_hit ? r_rd_data : '0;
    assign wide = {cur[ssn_pkg::SUM_W-1], cur}
                + {{(ssn_pkg::SUM_W - ssn_pkg::VAL_W + 1){r_value[ssn_pkg::VAL_W-1]}}, r_value};

    always_comb begin
        if (wide[ssn_pkg::SUM_W] != wide[ssn_pkg::SUM_W-1]) begin
            n_sum = wide[ssn_pkg::SUM_W] ? ~ssn_pkg::INT32_MAX : ssn_pkg::INT32_MAX;
        end else begin
            n_sum = wide[ssn_pkg::SUM_W-1:0];
        end
    end

    assign acc_write = r_pend && (r_type == ssn_pkg::REQ_ACC) && r_in_range;
    assign o_push    = r_pend && (r_type == ssn_pkg::REQ_NORM) && !i_full;
    assign exec_done = r_pend && ((r_type == ssn_pkg::REQ_ACC) || !i_full);

    assign o_job.value   = r_value;
    assign o_job.zero    = (cur == '0);
    assign o_job.divisor = (cur == '0) ? ssn_pkg::Q88_ONE : cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_valid <= '0;
        end else begin
            if (accept && ((i_req_type == ssn_pkg::REQ_ACC) ||
                           (i_req_type == ssn_pkg::REQ_NORM))) begin
                r_pend <= 1'b1;
            end else if (exec_done) begin
                r_pend <= 1'b0;
            end
            if (accept && (i_req_type == ssn_pkg::REQ_CLEAR)) begin
                r_valid <= '0;
            end else if (acc_write) begin
                r_valid[r_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_type     <= i_req_type;
            r_value    <= i_sample_value;
            r_idx      <= idx;
            r_in_range <= in_range;
            r_hit      <= in_range && r_valid[idx];
        end
    end

    // sum memory: one read port at accept, one write port at execute
    always_ff @(posedge i_clk) begin
        if (accept && in_range) begin
            r_rd_data <= r_mem[idx];
        end
        if (acc_write) begin
            r_mem[r_idx] <= n_sum;
        end
    end

endmodule

### design/ssn_queue.sv
// short job queue between front and back ends
// depends on ssn_pkg for the job type and depth
module ssn_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  ssn_pkg::t_norm_job          i_job,
    output logic                        o_full,
    input  logic                        i_pop,
    output ssn_pkg::t_norm_job          o_job,
    output logic                        o_empty,
    output logic [ssn_pkg::QCW-1:0]     o_count
);

    ssn_pkg::t_norm_job        r_slot [ssn_pkg::QUEUE_DEPTH];
    logic [ssn_pkg::QAW-1:0]   r_wp;
    logic [ssn_pkg::QAW-1:0]   r_rp;
    logic [ssn_pkg::QCW-1:0]   r_count;

    assign o_full  = (r_count == ssn_pkg::QCW'(ssn_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_slot[r_rp];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

endmodule

### design/ssn_back.sv
// back end: radix-2 restoring divider, one quotient bit per cycle,
// with sign fix-up and saturation to Q16.16; uses ssn_pkg
module ssn_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_empty,
    output logic                               o_pop,
    input  ssn_pkg::t_norm_job                 i_job,
    output logic                               o_strobe,
    output logic signed [ssn_pkg::SUM_W-1:0]   o_proportion,
    output logic                               o_sum_was_zero
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam int CW = $clog2(ssn_pkg::SUM_W);

    logic [1:0]                r_state;
    logic [1:0]                n_state;
    logic [CW-1:0]             r_cnt;
    logic [ssn_pkg::SUM_W-1:0] r_quo;
    logic [ssn_pkg::SUM_W-1:0] r_rem;
    logic [ssn_pkg::SUM_W-1:0] r_den;
    logic                      r_neg;
    logic                      r_zero;

    logic [ssn_pkg::SUM_W-1:0] num;
    logic [ssn_pkg::SUM_W-1:0] num_mag;
    logic [ssn_pkg::SUM_W-1:0] den_mag;
    logic [ssn_pkg::SUM_W:0]   rem_sh;
    logic [ssn_pkg::SUM_W:0]   rem_sub;
    logic [ssn_pkg::SUM_W-1:0] res;

    // value scaled by 2^16 fills exactly 32 bits
    assign num     = {i_job.value, 16'h0000};
    assign num_mag = num[ssn_pkg::SUM_W-1] ? (~num + 1'b1) : num;
    assign den_mag = i_job.divisor[ssn_pkg::SUM_W-1] ? (~i_job.divisor + 1'b1)
                                                      : i_job.divisor;

    assign rem_sh  = {r_rem, r_quo[ssn_pkg::SUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};

    assign o_pop = (r_state == ST_IDLE) && !i_empty;

    // magnitude never exceeds 2^31, so only the positive side saturates
    always_comb begin
        if (r_neg) begin
            res = '0 - r_quo;
        end else if (r_quo[ssn_pkg::SUM_W-1]) begin
            res = ssn_pkg::INT32_MAX;
        end else begin
            res = r_quo;
        end
    end

    always_comb begin
        case (r_state)
            ST_IDLE: n_state = i_empty ? ST_IDLE : ST_DIV;
            ST_DIV:  n_state = (r_cnt == CW'(ssn_pkg::SUM_W - 1)) ? ST_FIN : ST_DIV;
            ST_FIN:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= (r_state == ST_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_quo  <= num_mag;
                r_den  <= den_mag;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_neg  <= i_job.value[ssn_pkg::VAL_W-1] ^ i_job.divisor[ssn_pkg::SUM_W-1];
                r_zero <= i_job.zero;
            end
            ST_DIV: begin
                r_cnt <= r_cnt + 1'b1;
                if (!rem_sub[ssn_pkg::SUM_W]) begin
                    r_rem <= rem_sub[ssn_pkg::SUM_W-1:0];
                    r_quo <= {r_quo[ssn_pkg::SUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[ssn_pkg::SUM_W-1:0];
                    r_quo <= {r_quo[ssn_pkg::SUM_W-2:0], 1'b0};
                end
            end
            ST_FIN: begin
                o_proportion   <= res;
                o_sum_was_zero <= r_zero;
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

endmodule

### design/segment_sum_normalizer_unit.sv
// top level of the segment sum normaliser: front end, job queue, divider back end
// depends on ssn_pkg, ssn_front, ssn_queue and ssn_back
//
// A transaction is taken when start is high and busy is low. A clear does not raise busy;
// an accumulate holds busy for the read-modify-write of the per-bin sum memory, and a
// normalise holds it until its job goes into the two-entry queue, stalling while it is full.
// The divider takes one job at a time from the queue and yields one quotient bit per cycle,
// so new transactions can be taken while a division is still running. Each
// result is shown for one cycle with o_result_strobe; the receiver cannot hold it off.
// Results come out in transaction order. Only bins below NUM_BINS (and below 64) hold sums.
module segment_sum_normalizer_unit #(
    parameter int NUM_BINS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_req_type,
    input  logic signed [ssn_pkg::VAL_W-1:0]   i_sample_value,
    input  logic [ssn_pkg::BIN_W-1:0]          i_bin_index,
    output logic                               o_result_strobe,
    output logic signed [ssn_pkg::SUM_W-1:0]   o_proportion,
    output logic                               o_sum_was_zero
);

    logic                       push;
    logic                       pop;
    logic                       full;
    logic                       empty;
    logic [ssn_pkg::QCW-1:0]    q_count;
    ssn_pkg::t_norm_job         job_in;
    ssn_pkg::t_norm_job         job_out;

    ssn_front #(
        .NUM_BINS (NUM_BINS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_req_type     (i_req_type),
        .i_sample_value (i_sample_value),
        .i_bin_index    (i_bin_index),
        .o_push         (push),
        .o_job          (job_in),
        .i_full         (full)
    );

    ssn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_empty (empty),
        .o_count (q_count)
    );

    ssn_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .o_pop          (pop),
        .i_job          (job_out),
        .o_strobe       (o_result_strobe),
        .o_proportion   (o_proportion),
        .o_sum_was_zero (o_sum_was_zero)
    );

    // accumulate and normalise always raise busy once they are taken
    a_work_holds_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && ((i_req_type == ssn_pkg::REQ_ACC) ||
                            (i_req_type == ssn_pkg::REQ_NORM))) |=> busy)
        else $error("front end did not hold busy after taking work");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= ssn_pkg::QCW'(ssn_pkg::QUEUE_DEPTH))
        else $error("job queue overfilled");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !push || pop)
        else $error("push into a full queue");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("result strobe held for more than one cycle");

endmodule
